// ===== src/pet_pkg.sv =====
// Types and constants shared by the pheromone edge table modules.
// No dependencies.
package pet_pkg;

  // Command codes on the input item.
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_INC    = 3'd2;
  localparam logic [2:0] CMD_EVAP   = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INIT    = 3'd0;
  localparam logic [2:0] CFG_RATE    = 3'd1;
  localparam logic [2:0] CFG_FLOOR   = 3'd2;
  localparam logic [2:0] CFG_CEILING = 3'd3;
  localparam logic [2:0] CFG_CEIL_EN = 3'd4;

  localparam logic [31:0] ABSENT_VALUE = 32'hFFFF_0000;
  localparam logic [30:0] PHERO_MAX    = 31'h7FFF_FFFF;
  localparam logic [16:0] ONE_Q16      = 17'h1_0000;

  // Operation after classification by the front.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_INC,
    OP_EVAP,
    OP_RESET,
    OP_REPORT
  } op_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         node_first;
    logic [5:0]         node_second;
    logic signed [31:0] distance;
    logic [30:0]        amount;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic               edge_exists;
    logic signed [31:0] length;
    logic signed [31:0] pheromone;
  } res_t;

  typedef struct packed {
    logic [30:0] initial_pheromone;
    logic [16:0] evaporation_rate;
    logic [30:0] pheromone_floor;
    logic [30:0] pheromone_ceiling;
    logic        ceiling_enable;
  } cfg_t;

  // Classified item passed from front to back.
  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic signed [31:0] distance;
    logic [30:0]        amount;
  } item_t;

  // One word of the edge store.
  typedef struct packed {
    logic        valid;
    logic [30:0] length;
    logic [30:0] phero;
  } entry_t;

endpackage

// ===== src/pheromone_edge_table.sv =====
// Top level of the pheromone edge table (max-min ant colony variant).
// Depends on pet_pkg, pet_front, pet_queue and pet_back (with pet_ram).
//
//  channel   direction  handshake                 payload
//  command   in         start high, busy low      cmd_i   (pet_pkg::cmd_t)
//  result    out        done_o strobe, 1 cycle    res_o   (pet_pkg::res_t)
//  config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Flow: the front registers an accepted item and pushes it into the queue; the back pops it,
// reads the store slot, executes an add, lookup or increment, writes back any change and
// registers the result strobe, finishing one item before it pops the next. Evaporate (nonzero
// rate up to 1.0) and reset walk all NODE_COUNT*NODE_COUNT slots in three stages, then report.
// Reset: busy holds high through a clearing pass that writes every slot of the store invalid.
// Stalls: busy rises when the front holds an item and the queue is full; no receiver stall.
module pheromone_edge_table #(
  parameter int NODE_COUNT  = 64,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pet_pkg::cmd_t cmd_i,
  output logic          done_o,
  output pet_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int SLOT_W = $clog2(NODE_COUNT * NODE_COUNT);
  localparam int QW     = SLOT_W + $bits(pet_pkg::item_t);

  pet_pkg::cfg_t     cfg_q, cfg_d;
  logic              clearing;
  logic              q_full, q_empty, q_push, q_pop;
  pet_pkg::item_t    f_item, q_item;
  logic [SLOT_W-1:0] f_slot, q_slot;
  logic [QW-1:0]     q_out;

  // Config port never stalls; software must write only while the block is idle (unchecked).
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pet_pkg::CFG_INIT:    cfg_d.initial_pheromone = cfg_data_i[30:0];
        pet_pkg::CFG_RATE:    cfg_d.evaporation_rate  = cfg_data_i[16:0];
        pet_pkg::CFG_FLOOR:   cfg_d.pheromone_floor   = cfg_data_i[30:0];
        pet_pkg::CFG_CEILING: cfg_d.pheromone_ceiling = cfg_data_i[30:0];
        pet_pkg::CFG_CEIL_EN: cfg_d.ceiling_enable    = cfg_data_i[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_pheromone <= 31'd65536;
      cfg_q.evaporation_rate  <= 17'd6554;
      cfg_q.pheromone_floor   <= 31'd0;
      cfg_q.pheromone_ceiling <= pet_pkg::PHERO_MAX;
      cfg_q.ceiling_enable    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept, map the node pair to its slot, classify.
  pet_front #(
    .NODE_COUNT(NODE_COUNT),
    .SLOT_W    (SLOT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .rate_i      (cfg_q.evaporation_rate),
    .clearing_i  (clearing),
    .queue_full_i(q_full),
    .busy_o      (busy),
    .push_o      (q_push),
    .item_o      (f_item),
    .slot_o      (f_slot)
  );

  // Queue: decouple the front from store sweeps in the back.
  pet_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({f_slot, f_item}),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign q_slot = q_out[QW-1 -: SLOT_W];
  assign q_item = pet_pkg::item_t'(q_out[$bits(pet_pkg::item_t)-1:0]);

  // Back: execute against the edge store and strobe the result.
  pet_back #(
    .NODE_COUNT(NODE_COUNT),
    .SLOT_W    (SLOT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_slot_i  (q_slot),
    .q_pop_o   (q_pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule

// ===== src/pet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pet_queue.sv =====
// Small FIFO between the front and back of the edge table.
// No dependencies.
module pet_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/pet_front.sv =====
// Front of the edge table: takes commands, maps the node pair to a slot
// and classifies the operation. Depends on pet_pkg.
module pet_front #(
  parameter int NODE_COUNT = 64,
  parameter int SLOT_W     = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pet_pkg::cmd_t       cmd_i,
  input  logic [16:0]         rate_i,
  input  logic                clearing_i,
  input  logic                queue_full_i,
  output logic                busy_o,
  output logic                push_o,
  output pet_pkg::item_t      item_o,
  output logic [SLOT_W-1:0]   slot_o
);

  logic                vld_q, vld_d;
  pet_pkg::item_t      item_q, item_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                accept;
  logic [5:0]          lo, hi;
  logic                evap_active;

  assign busy_o = clearing_i || (vld_q && queue_full_i);
  assign accept = start_i && !busy_o;
  assign push_o = vld_q && !queue_full_i;
  assign item_o = item_q;
  assign slot_o = slot_q;

  assign lo = (cmd_i.node_first < cmd_i.node_second) ? cmd_i.node_first : cmd_i.node_second;
  assign hi = (cmd_i.node_first < cmd_i.node_second) ? cmd_i.node_second : cmd_i.node_first;
  assign evap_active = (rate_i != '0) && (rate_i <= pet_pkg::ONE_Q16);

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    slot_d = slot_q;
    if (push_o) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d           = 1'b1;
      item_d.in_range = (32'(hi) < 32'(NODE_COUNT));
      item_d.distance = cmd_i.distance;
      item_d.amount   = cmd_i.amount;
      slot_d          = SLOT_W'(lo) * SLOT_W'(NODE_COUNT) + SLOT_W'(hi);
      case (cmd_i.command)
        pet_pkg::CMD_ADD:    item_d.op = pet_pkg::OP_ADD;
        pet_pkg::CMD_INC:    item_d.op = pet_pkg::OP_INC;
        pet_pkg::CMD_EVAP:   item_d.op = evap_active ? pet_pkg::OP_EVAP : pet_pkg::OP_REPORT;
        pet_pkg::CMD_RESET:  item_d.op = pet_pkg::OP_RESET;
        default:             item_d.op = pet_pkg::OP_REPORT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
  end

endmodule

// ===== src/pet_back.sv =====
// Back of the edge table: owns the edge store, clears it after reset,
// runs single-edge commands and the evaporate / reset sweeps.
// Depends on pet_pkg and pet_ram.
module pet_back #(
  parameter int NODE_COUNT = 64,
  parameter int SLOT_W     = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pet_pkg::cfg_t     cfg_i,
  input  logic              q_empty_i,
  input  pet_pkg::item_t    q_item_i,
  input  logic [SLOT_W-1:0] q_slot_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              done_o,
  output pet_pkg::res_t     res_o
);

  localparam int SLOTS = NODE_COUNT * NODE_COUNT;
  localparam int EW    = $bits(pet_pkg::entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W:0]   cnt_q, cnt_d;
  logic              s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  logic              done_q, done_d;
  pet_pkg::res_t     res_q, res_d;

  pet_pkg::item_t    item_q, item_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] s1_addr_q, s1_addr_d, s2_addr_q, s2_addr_d;
  pet_pkg::entry_t   s2_ent_q, s2_ent_d;
  logic [46:0]       s2_prod_q, s2_prod_d;

  logic              we, re;
  logic [SLOT_W-1:0] waddr, raddr;
  pet_pkg::entry_t   wdata, rdata;
  logic [EW-1:0]     rdata_raw;

  pet_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(EW'(wdata)),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata      = pet_pkg::entry_t'(rdata_raw);
  assign clearing_o = (state_q == ST_CLEAR);
  assign done_o     = done_q;
  assign res_o      = res_q;

  always_comb begin
    logic [15:0]     keep;
    logic [30:0]     scaled;
    logic [31:0]     sum;
    logic [30:0]     sat;
    logic            hit;
    pet_pkg::entry_t after;

    state_d   = state_q;
    cnt_d     = cnt_q;
    s1_vld_d  = 1'b0;
    s2_vld_d  = 1'b0;
    done_d    = 1'b0;
    res_d     = res_q;
    item_d    = item_q;
    slot_d    = slot_q;
    s1_addr_d = s1_addr_q;
    s2_addr_d = s1_addr_q;
    s2_ent_d  = rdata;
    keep      = 16'(pet_pkg::ONE_Q16 - cfg_i.evaporation_rate);
    s2_prod_d = 47'(rdata.phero) * 47'(keep);
    q_pop_o   = 1'b0;
    we        = 1'b0;
    waddr     = s2_addr_q;
    wdata     = s2_ent_q;
    re        = 1'b0;
    raddr     = slot_q;
    scaled    = s2_prod_q[46:16];
    sum       = {1'b0, rdata.phero} + {1'b0, item_q.amount};
    sat       = sum[31] ? pet_pkg::PHERO_MAX : sum[30:0];
    hit       = item_q.in_range && rdata.valid;
    after     = rdata;

    case (state_q)
      ST_CLEAR: begin
        // sweep every slot to invalid after reset
        we    = 1'b1;
        waddr = cnt_q[SLOT_W-1:0];
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (SLOT_W + 1)'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          slot_d  = q_slot_i;
          cnt_d   = '0;
          if (q_item_i.op == pet_pkg::OP_EVAP || q_item_i.op == pet_pkg::OP_RESET) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SWEEP: begin
        // stage 0: read next slot
        if (cnt_q != (SLOT_W + 1)'(SLOTS)) begin
          re        = 1'b1;
          raddr     = cnt_q[SLOT_W-1:0];
          cnt_d     = cnt_q + 1'b1;
          s1_vld_d  = 1'b1;
          s1_addr_d = cnt_q[SLOT_W-1:0];
        end
        // stage 1: data back, multiply into stage 2
        s2_vld_d = s1_vld_q && rdata.valid;
        // stage 2: clamp to the floor (evaporate) or load the initial level (reset), and write back
        if (s2_vld_q) begin
          we = 1'b1;
          if (item_q.op == pet_pkg::OP_RESET) begin
            wdata.phero = cfg_i.initial_pheromone;
          end else begin
            wdata.phero = (scaled < cfg_i.pheromone_floor) ? cfg_i.pheromone_floor : scaled;
          end
        end
        if (cnt_q == (SLOT_W + 1)'(SLOTS) && !s1_vld_q && !s2_vld_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        re      = 1'b1;
        raddr   = slot_q;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        waddr = slot_q;
        wdata = after;
        res_d.accepted = 1'b0;
        case (item_q.op)
          pet_pkg::OP_ADD: begin
            if (item_q.in_range && !rdata.valid && !item_q.distance[31]) begin
              after.valid    = 1'b1;
              after.length   = item_q.distance[30:0];
              after.phero    = cfg_i.initial_pheromone;
              wdata          = after;
              we             = 1'b1;
              res_d.accepted = 1'b1;
            end
          end
          pet_pkg::OP_INC: begin
            if (hit && item_q.amount != '0) begin
              after.phero = (cfg_i.ceiling_enable && sat > cfg_i.pheromone_ceiling) ?
                            cfg_i.pheromone_ceiling : sat;
              wdata       = after;
              we          = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (item_q.in_range && after.valid) begin
          res_d.edge_exists = 1'b1;
          res_d.length      = {1'b0, after.length};
          res_d.pheromone   = {1'b0, after.phero};
        end else begin
          res_d.edge_exists = 1'b0;
          res_d.length      = pet_pkg::ABSENT_VALUE;
          res_d.pheromone   = pet_pkg::ABSENT_VALUE;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    slot_q    <= slot_d;
    s1_addr_q <= s1_addr_d;
    s2_addr_q <= s2_addr_d;
    s2_ent_q  <= s2_ent_d;
    s2_prod_q <= s2_prod_d;
  end

endmodule

// ===== bench/tb_pheromone_edge_table.sv =====
// Self-checking testbench for the pheromone edge table: directed and random
// command items, checked result by result against an in-bench table predictor.
// Depends on pet_pkg and the pheromone_edge_table RTL.
`timescale 1ns / 100ps

module tb_pheromone_edge_table;

  localparam int NODES        = 64;
  localparam int SLOT_COUNT   = NODES * NODES;
  localparam int PHASE_ITEMS  = 150;  // four random phases, about 600 items
  localparam int PHASE_COUNT  = 4;
  localparam int SETTLE_WAIT  = 8;    // idle wait after the last predicted result is checked

  // Codes 5..7 are not assigned; the block must leave the table alone on them.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam pet_pkg::cfg_t RESET_CFG = '{
    initial_pheromone: 31'h0001_0000,
    evaporation_rate:  17'd6554,
    pheromone_floor:   31'd0,
    pheromone_ceiling: 31'h7FFF_FFFF,
    ceiling_enable:    1'b0
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  pet_pkg::cmd_t cmd_i = '0;
  logic          done_o;
  pet_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i = '0;

  pheromone_edge_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted table contents and register settings, one slot per unordered pair.
  logic          edge_present [SLOT_COUNT];
  logic [31:0]   edge_length  [SLOT_COUNT];
  logic [30:0]   edge_level   [SLOT_COUNT];
  pet_pkg::cfg_t table_cfg;

  pet_pkg::res_t pending_results [$];
  pet_pkg::res_t oldest_result;
  int            error_count = 0;
  bit            burst_mode = 1'b0;

  // Run one command against the predicted table and return the edge report.
  function automatic pet_pkg::res_t predict_table(pet_pkg::cmd_t c);
    logic [5:0]    lo;
    logic [5:0]    hi;
    logic [11:0]   slot;
    logic [32:0]   sum;
    logic [47:0]   scaled;
    logic [16:0]   keep;
    pet_pkg::res_t r;
    lo = (c.node_first < c.node_second) ? c.node_first : c.node_second;
    hi = (c.node_first < c.node_second) ? c.node_second : c.node_first;
    slot = {lo, hi};
    r = '0;
    case (c.command)
      pet_pkg::CMD_ADD: begin
        // Reject duplicates and negative lengths.
        if (!edge_present[slot] && !c.distance[31]) begin
          edge_present[slot] = 1'b1;
          edge_length[slot]  = c.distance;
          edge_level[slot]   = table_cfg.initial_pheromone;
          r.accepted = 1'b1;
        end
      end
      pet_pkg::CMD_INC: begin
        if (edge_present[slot] && c.amount != '0) begin
          sum = {2'b00, edge_level[slot]} + {2'b00, c.amount};
          if (sum > {2'b00, pet_pkg::PHERO_MAX})
            sum = {2'b00, pet_pkg::PHERO_MAX};
          if (table_cfg.ceiling_enable && sum > {2'b00, table_cfg.pheromone_ceiling})
            sum = {2'b00, table_cfg.pheromone_ceiling};
          edge_level[slot] = sum[30:0];
        end
      end
      pet_pkg::CMD_EVAP: begin
        // Zero or anything past 1.0 leaves the table alone.
        if (table_cfg.evaporation_rate != '0 &&
            table_cfg.evaporation_rate <= pet_pkg::ONE_Q16) begin
          keep = pet_pkg::ONE_Q16 - table_cfg.evaporation_rate;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (edge_present[i]) begin
              scaled = {17'd0, edge_level[i]} * {31'd0, keep};
              edge_level[i] = scaled[46:16];
              if (edge_level[i] < table_cfg.pheromone_floor)
                edge_level[i] = table_cfg.pheromone_floor;
            end
          end
        end
      end
      pet_pkg::CMD_RESET: begin
        for (int i = 0; i < SLOT_COUNT; i++)
          if (edge_present[i])
            edge_level[i] = table_cfg.initial_pheromone;
      end
      default: ;
    endcase
    if (edge_present[slot]) begin
      r.edge_exists = 1'b1;
      r.length      = edge_length[slot];
      r.pheromone   = {1'b0, edge_level[slot]};
    end else begin
      r.length    = pet_pkg::ABSENT_VALUE;
      r.pheromone = pet_pkg::ABSENT_VALUE;
    end
    return r;
  endfunction

  function automatic pet_pkg::cmd_t edge_item(logic [2:0] command, logic [5:0] a,
                                              logic [5:0] b, logic [31:0] distance,
                                              logic [30:0] amount);
    pet_pkg::cmd_t c;
    c.command     = command;
    c.node_first  = a;
    c.node_second = b;
    c.distance    = distance;
    c.amount      = amount;
    return c;
  endfunction

  // Mostly a small pool at both ends of the node range, so edges get reused.
  function automatic logic [5:0] random_node();
    logic [31:0] word;
    logic [5:0]  v;
    int unsigned n;
    word = $urandom();
    if ($urandom_range(0, 4) == 0)
      return word[5:0];
    n = $urandom_range(0, 7);
    v = n[5:0];
    if (n >= 4)
      v = v + 6'd56;
    return v;
  endfunction

  function automatic pet_pkg::cmd_t random_item();
    pet_pkg::cmd_t c;
    int unsigned   pick;
    logic [31:0]   word;
    logic [2:0]    unused_code;
    pick = $urandom_range(0, 99);
    unused_code = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if (pick < 30)      c.command = pet_pkg::CMD_ADD;
    else if (pick < 55) c.command = pet_pkg::CMD_LOOKUP;
    else if (pick < 87) c.command = pet_pkg::CMD_INC;
    else if (pick < 91) c.command = unused_code;
    else if (pick < 95) c.command = pet_pkg::CMD_EVAP;
    else                c.command = pet_pkg::CMD_RESET;
    c.node_first  = random_node();
    c.node_second = random_node();
    // Mostly non-negative lengths; a fifth may be negative and get rejected.
    if ($urandom_range(0, 4) == 0)
      c.distance = $urandom();
    else
      c.distance = $urandom_range(0, 32'h7FFF_FFFF);
    word = $urandom();
    case ($urandom_range(0, 9))
      0:       c.amount = '0;
      1, 2:    c.amount = word[30:0];
      default: c.amount = 31'($urandom_range(1, 32'h3_FFFF));
    endcase
    return c;
  endfunction

  // Present one item, after a random gap unless in burst mode, and hold it until the block takes it.
  // Busy is sampled at the falling edge, where it already shows what the next
  // rising edge will see.
  task automatic send_item(input pet_pkg::cmd_t c);
    int unsigned gap;
    bit          take;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do begin
      @(negedge clk_i);
      take = !busy;
      @(posedge clk_i);
    end while (!take);
    pending_results.push_back(predict_table(c));
  endtask

  // Write one register; valid stays high so writes can go back to back.
  task automatic write_register(input logic [2:0] index, input logic [31:0] data);
    bit take;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      take = cfg_ready_o;
      @(posedge clk_i);
    end while (!take);
    case (index)
      pet_pkg::CFG_INIT:    table_cfg.initial_pheromone = data[30:0];
      pet_pkg::CFG_RATE:    table_cfg.evaporation_rate  = data[16:0];
      pet_pkg::CFG_FLOOR:   table_cfg.pheromone_floor   = data[30:0];
      pet_pkg::CFG_CEILING: table_cfg.pheromone_ceiling = data[30:0];
      pet_pkg::CFG_CEIL_EN: table_cfg.ceiling_enable    = data[0];
      default: ;
    endcase
  endtask

  // Write every register; call only while the block is idle.
  task automatic load_config(input pet_pkg::cfg_t c);
    @(posedge clk_i);
    write_register(pet_pkg::CFG_INIT,    {1'b0, c.initial_pheromone});
    write_register(pet_pkg::CFG_RATE,    {15'd0, c.evaporation_rate});
    write_register(pet_pkg::CFG_FLOOR,   {1'b0, c.pheromone_floor});
    write_register(pet_pkg::CFG_CEILING, {1'b0, c.pheromone_ceiling});
    write_register(pet_pkg::CFG_CEIL_EN, {31'd0, c.ceiling_enable});
    cfg_valid_i <= 1'b0;
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic settle_table();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic test_add_and_lookup();
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd0,  6'd0,  32'h0000_0000, 31'd0));  // self loop
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd63, 6'd0,  32'h7FFF_FFFF, 31'd0));
    // same edge reversed
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd0,  6'd63, 32'h0000_0005, 31'd0));
    // negative length
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd9,  6'd5,  32'h8000_0000, 31'd0));
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd5,  6'd9,  32'hFFFF_FFFF, 31'd0));
    // still absent
    send_item(edge_item(pet_pkg::CMD_LOOKUP, 6'd9,  6'd5,  32'h0,         31'd0));
    send_item(edge_item(pet_pkg::CMD_ADD,    6'd5,  6'd9,  32'h1234_5678, 31'h7FFF_FFFF));
    send_item(edge_item(pet_pkg::CMD_LOOKUP, 6'd9,  6'd5,  32'hFFFF_FFFF, 31'd0));
    send_item(edge_item(pet_pkg::CMD_LOOKUP, 6'd63, 6'd0,  32'h0,         31'd0));
    settle_table();
  endtask

  task automatic test_increment();
    send_item(edge_item(pet_pkg::CMD_INC, 6'd63, 6'd0, 32'h0, 31'd0));          // zero amount
    send_item(edge_item(pet_pkg::CMD_INC, 6'd1,  6'd2, 32'h0, 31'd100));        // absent edge
    send_item(edge_item(pet_pkg::CMD_INC, 6'd0,  6'd0, 32'h0, 31'h7FFF_FFFF));  // saturates
    send_item(edge_item(pet_pkg::CMD_INC, 6'd5,  6'd9, 32'h0, 31'd1));
    settle_table();
  endtask

  task automatic test_table_walks();
    send_item(edge_item(pet_pkg::CMD_EVAP,  6'd0,  6'd0,  32'h0, 31'd0));
    send_item(edge_item(pet_pkg::CMD_RESET, 6'd9,  6'd5,  32'h0, 31'd0));
    send_item(edge_item(CMD_UNUSED_LO,      6'd0,  6'd63, 32'h0, 31'd5));
    send_item(edge_item(CMD_UNUSED_LO + 3'd1, 6'd9, 6'd5, 32'h0, 31'd5));
    send_item(edge_item(CMD_UNUSED_HI,      6'd3,  6'd3,  32'h7, 31'd5));
    settle_table();
  endtask

  task automatic test_ceiling_clamp();
    pet_pkg::cfg_t c;
    c = table_cfg;
    c.pheromone_ceiling = 31'h0003_0000;
    c.ceiling_enable    = 1'b1;
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_INC, 6'd5, 6'd9, 32'h0, 31'h0001_0000));
    send_item(edge_item(pet_pkg::CMD_INC, 6'd9, 6'd5, 32'h0, 31'h0001_0000));  // reaches the ceiling
    // stays below the ceiling
    send_item(edge_item(pet_pkg::CMD_INC, 6'd0, 6'd0, 32'h0, 31'd1));
    settle_table();
  endtask

  task automatic test_evaporation_limits();
    pet_pkg::cfg_t c;
    c = table_cfg;
    c.evaporation_rate = pet_pkg::ONE_Q16;  // everything drops to the floor
    c.pheromone_floor  = 31'h123;
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_EVAP, 6'd63, 6'd0, 32'h0, 31'd0));
    settle_table();
    c.evaporation_rate = '0;
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_INC,  6'd0, 6'd0, 32'h0, 31'h4_0000));
    send_item(edge_item(pet_pkg::CMD_EVAP, 6'd0, 6'd0, 32'h0, 31'd0));
    settle_table();
    c.evaporation_rate = 17'h1_FFFF;  // past 1.0, ignored
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_EVAP, 6'd0, 6'd0, 32'h0, 31'd0));
    settle_table();
    c.initial_pheromone = 31'h7FFF_FFFF;
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_RESET, 6'd5, 6'd9, 32'h0, 31'd0));
    settle_table();
    c.initial_pheromone = '0;
    c.evaporation_rate  = 17'd1;
    load_config(c);
    send_item(edge_item(pet_pkg::CMD_ADD,  6'd2, 6'd3, 32'h0000_1000, 31'd0));
    // new edge raised to floor
    send_item(edge_item(pet_pkg::CMD_EVAP, 6'd3, 6'd2, 32'h0, 31'd0));
    settle_table();
  endtask

  // Random traffic in phases, each under its own register setting.
  task automatic test_random_traffic();
    pet_pkg::cfg_t c;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: c = RESET_CFG;
        1: begin
          c.initial_pheromone = 31'($urandom_range(0, 32'h7_FFFF));
          c.evaporation_rate  = 17'($urandom_range(1, pet_pkg::ONE_Q16));
          c.pheromone_floor   = 31'($urandom_range(0, 32'hFFFF));
          c.pheromone_ceiling = 31'($urandom_range(32'h1_0000, 32'h7F_FFFF));
          c.ceiling_enable    = 1'b1;
        end
        2: begin
          c.initial_pheromone = 31'h7FFF_FFFF;
          c.evaporation_rate  = 17'd1;
          c.pheromone_floor   = 31'h7FFF_FFFF;
          c.pheromone_ceiling = '0;
          c.ceiling_enable    = 1'b1;
        end
        default: begin
          c.initial_pheromone = '0;
          c.evaporation_rate  = pet_pkg::ONE_Q16 - 17'd1;
          c.pheromone_floor   = '0;
          c.pheromone_ceiling = 31'h7FFF_FFFF;
          c.ceiling_enable    = 1'b0;
        end
      endcase
      load_config(c);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Switch between back-to-back bursts and gapped traffic now and then.
        if (k % 25 == 0)
          burst_mode = ($urandom_range(0, 2) == 0);
        send_item(random_item());
      end
      burst_mode = 1'b0;
      settle_table();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every strobed result with the oldest prediction.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: accepted %b exists %b length %h pheromone %h",
               res_o.accepted, res_o.edge_exists, res_o.length, res_o.pheromone);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("accepted",    {31'd0, oldest_result.accepted},    {31'd0, res_o.accepted});
        check_field("edge_exists", {31'd0, oldest_result.edge_exists},
                    {31'd0, res_o.edge_exists});
        check_field("length",      oldest_result.length,               res_o.length);
        check_field("pheromone",   oldest_result.pheromone,            res_o.pheromone);
      end
    end
  end

  initial begin
    table_cfg = RESET_CFG;
    for (int i = 0; i < SLOT_COUNT; i++)
      edge_present[i] = 1'b0;
    // Hold reset at the start; after release the block clears its store while busy.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_add_and_lookup();
    test_increment();
    test_table_walks();
    test_ceiling_clamp();
    test_evaporation_limits();
    test_random_traffic();
    settle_table();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0)
      $display("tb_pheromone_edge_table passed");
    else
      $display("tb_pheromone_edge_table failed");
    $finish;
  end

  // Watchdog: many times the slowest legal run, table walks included.
  initial begin
    #50_000_000;
    $display("tb_pheromone_edge_table failed");
    $finish;
  end

endmodule
